// ===== rtl/spd_pkg.sv =====
// ----------------------------------------------------------------------------
// spd_pkg
// Shared types and constants for the slotted page directory.
// ----------------------------------------------------------------------------
package spd_pkg;

    // page geometry (fixed by the 13-bit offset and length fields)
    localparam int PAGE_BYTES        = 4096;
    localparam int PAGE_HEADER_BYTES = 16;
    localparam int DIR_META_BYTES    = 2 * 2;   // slot count + free pointer, 16 bits each
    localparam int ENTRY_BYTES       = 4;
    localparam int MAX_ENTRIES       = 64;

    localparam int CMD_W  = 2;
    localparam int SLOT_W = 6;
    localparam int BYTE_W = 13;
    localparam int STAT_W = 2;

    // commands
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_GET    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SCAN   = 2'd3;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NO_SPACE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BAD_SLOT = 2'd2;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [SLOT_W-1:0] slot_number;
        logic [BYTE_W-1:0] record_length;
    } spd_cmd_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] slot_out;
        logic [BYTE_W-1:0] byte_offset;
        logic [BYTE_W-1:0] byte_length;
        logic              last;
    } spd_rsp_t;

endpackage

// ===== rtl/spd_ram.sv =====
// ----------------------------------------------------------------------------
// spd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module spd_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/slotted_page_directory.sv =====
// ----------------------------------------------------------------------------
// slotted_page_directory
// Slot directory of one database page: insert, remove, get and scan.
// ----------------------------------------------------------------------------
// Slot offsets and lengths live in two RAMs of SLOT_DEPTH words; slot count
// and free pointer are registers. One command word is taken at a time.
// Remove answers through the send state; get reads both RAMs and builds its
// result word in the get state. Insert and scan walk the length RAM one slot
// per cycle while the output is not stalled (insert stops early at the first
// zero-length slot). A scan gives one word per live slot, or one empty word
// when none is live, and stalls when the output is not taken. A failed gap
// check on insert answers from the send state without a walk. The RAMs need
// no init pass after reset: only slots below the slot count are ever read.
module slotted_page_directory
    import spd_pkg::*;
#(
    parameter int SLOT_DEPTH = spd_pkg::MAX_ENTRIES
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    output logic     cmd_ready,
    input  spd_cmd_t cmd,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output spd_rsp_t rsp
);

    localparam int CNT_W  = $clog2(SLOT_DEPTH + 1);
    localparam int IDX_W  = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
    localparam int CMP_W  = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
    localparam int SUM_W  = (CNT_W + 3 > BYTE_W + 1) ? CNT_W + 3 : BYTE_W + 1;
    // page header and directory meta plus room for one more entry
    localparam int DIR_BASE = PAGE_HEADER_BYTES + DIR_META_BYTES + ENTRY_BYTES;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_GET  = 2'd2;
    localparam logic [1:0] ST_SEND = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [BYTE_W-1:0] free_start_reg, free_start_next;
    logic              out_valid_reg, out_valid_next;
    logic              chk_vld_reg, chk_vld_next;
    logic              pend_vld_reg, pend_vld_next;

    logic [CMD_W-1:0]  op_reg, op_next;
    logic [CNT_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]  chk_idx_reg, chk_idx_next;
    logic [BYTE_W-1:0] off_reg, off_next;
    logic [BYTE_W-1:0] len_reg, len_next;
    spd_rsp_t          res_reg, res_next;
    spd_rsp_t          pend_reg, pend_next;
    spd_rsp_t          out_reg, out_next;

    // RAM ports
    logic              ram_re;
    logic [IDX_W-1:0]  ram_raddr;
    logic              off_we, len_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [BYTE_W-1:0] off_wdata, len_wdata;
    logic [BYTE_W-1:0] off_rdata, len_rdata;

    logic              out_free;
    logic [SUM_W-1:0]  need, fs_ext, gap;
    logic              gap_fail;
    logic [CMP_W-1:0]  sn_ext;
    logic              bad_slot;
    logic [IDX_W-1:0]  sn_idx;
    logic              issue, walk_done, chk_free, chk_live;

    spd_ram #(.WIDTH(BYTE_W), .DEPTH(SLOT_DEPTH)) u_off_ram (
        .clk   (clk),
        .we    (off_we),
        .waddr (ram_waddr),
        .wdata (off_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (off_rdata)
    );

    spd_ram #(.WIDTH(BYTE_W), .DEPTH(SLOT_DEPTH)) u_len_ram (
        .clk   (clk),
        .we    (len_we),
        .waddr (ram_waddr),
        .wdata (len_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (len_rdata)
    );

    assign out_free  = !out_valid_reg || rsp_ready;
    assign cmd_ready = (state_reg == ST_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // free gap check, a negative gap fails too
    assign need     = SUM_W'(DIR_BASE) + (SUM_W'(count_reg) << 2);
    assign fs_ext   = SUM_W'(free_start_reg);
    assign gap      = fs_ext - need;
    assign gap_fail = (fs_ext < need) || (gap < SUM_W'(cmd.record_length));

    assign sn_ext   = CMP_W'(cmd.slot_number);
    assign bad_slot = sn_ext >= CMP_W'(count_reg);
    assign sn_idx   = IDX_W'(sn_ext);

    assign issue     = rd_idx_reg < count_reg;
    assign walk_done = !issue && !chk_vld_reg;
    assign chk_free  = chk_vld_reg && (len_rdata == '0);
    assign chk_live  = chk_vld_reg && (len_rdata != '0);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        free_start_next = free_start_reg;
        out_valid_next  = out_valid_reg && !rsp_ready;
        chk_vld_next    = chk_vld_reg;
        pend_vld_next   = pend_vld_reg;
        op_next         = op_reg;
        rd_idx_next     = rd_idx_reg;
        chk_idx_next    = chk_idx_reg;
        off_next        = off_reg;
        len_next        = len_reg;
        res_next        = res_reg;
        pend_next       = pend_reg;
        out_next        = out_reg;

        ram_re    = 1'b0;
        ram_raddr = rd_idx_reg[IDX_W-1:0];
        off_we    = 1'b0;
        len_we    = 1'b0;
        ram_waddr = chk_idx_reg;
        off_wdata = off_reg;
        len_wdata = len_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    op_next      = cmd.command;
                    rd_idx_next  = '0;
                    chk_vld_next = 1'b0;
                    pend_vld_next = 1'b0;
                    res_next     = '{status: STAT_BAD_SLOT, slot_out: '0,
                                     byte_offset: '0, byte_length: '0, last: 1'b1};
                    unique case (cmd.command)
                        CMD_INSERT:
                        begin
                            if (gap_fail)
                            begin
                                res_next.status = STAT_NO_SPACE;
                                state_next      = ST_SEND;
                            end
                            else
                            begin
                                off_next   = free_start_reg - cmd.record_length;
                                len_next   = cmd.record_length;
                                state_next = ST_WALK;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (!bad_slot)
                            begin
                                len_we            = 1'b1;
                                ram_waddr         = sn_idx;
                                len_wdata         = '0;
                                res_next.status   = STAT_OK;
                                res_next.slot_out = cmd.slot_number;
                            end
                            state_next = ST_SEND;
                        end
                        CMD_GET:
                        begin
                            if (bad_slot)
                            begin
                                state_next = ST_SEND;
                            end
                            else
                            begin
                                ram_re       = 1'b1;
                                ram_raddr    = sn_idx;
                                chk_idx_next = sn_idx;
                                state_next   = ST_GET;
                            end
                        end
                        CMD_SCAN:
                        begin
                            state_next = ST_WALK;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_GET:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '{status: STAT_OK, slot_out: SLOT_W'(chk_idx_reg),
                                       byte_offset: off_rdata, byte_length: len_rdata,
                                       last: 1'b1};
                    if (len_rdata == '0)
                    begin
                        out_next.status      = STAT_EMPTY;
                        out_next.byte_offset = '0;
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_SEND:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = res_reg;
                    state_next     = ST_IDLE;
                end
            end

            ST_WALK:
            begin
                if (op_reg == CMD_INSERT)
                begin
                    if (chk_free || walk_done)
                    begin
                        if (out_free)
                        begin
                            out_valid_next = 1'b1;
                            state_next     = ST_IDLE;
                            out_next       = '{status: STAT_OK, slot_out: '0,
                                               byte_offset: off_reg, byte_length: len_reg,
                                               last: 1'b1};
                            if (chk_free)
                            begin
                                // reuse first empty slot
                                off_we            = 1'b1;
                                len_we            = 1'b1;
                                free_start_next   = off_reg;
                                out_next.slot_out = SLOT_W'(chk_idx_reg);
                            end
                            else if (count_reg == CNT_W'(SLOT_DEPTH))
                            begin
                                out_next.status      = STAT_NO_SPACE;
                                out_next.byte_offset = '0;
                                out_next.byte_length = '0;
                            end
                            else
                            begin
                                // append
                                off_we            = 1'b1;
                                len_we            = 1'b1;
                                ram_waddr         = count_reg[IDX_W-1:0];
                                free_start_next   = off_reg;
                                count_next        = CNT_W'(count_reg + 1'b1);
                                out_next.slot_out = SLOT_W'(count_reg);
                            end
                        end
                    end
                    else
                    begin
                        ram_re       = issue;
                        rd_idx_next  = CNT_W'(rd_idx_reg + issue);
                        chk_vld_next = issue;
                        chk_idx_next = rd_idx_reg[IDX_W-1:0];
                    end
                end
                else
                begin
                    // scan: hold one live slot back so the final one can carry last
                    if (walk_done)
                    begin
                        if (out_free)
                        begin
                            out_valid_next = 1'b1;
                            state_next     = ST_IDLE;
                            if (pend_vld_reg)
                            begin
                                out_next      = pend_reg;
                                out_next.last = 1'b1;
                            end
                            else
                            begin
                                out_next = '{status: STAT_EMPTY, slot_out: '0,
                                             byte_offset: '0, byte_length: '0, last: 1'b1};
                            end
                        end
                    end
                    else if (!(chk_live && pend_vld_reg && !out_free))
                    begin
                        if (chk_live)
                        begin
                            if (pend_vld_reg)
                            begin
                                out_valid_next = 1'b1;
                                out_next       = pend_reg;
                            end
                            pend_vld_next = 1'b1;
                            pend_next     = '{status: STAT_OK,
                                              slot_out: SLOT_W'(chk_idx_reg),
                                              byte_offset: off_rdata,
                                              byte_length: len_rdata, last: 1'b0};
                        end
                        ram_re       = issue;
                        rd_idx_next  = CNT_W'(rd_idx_reg + issue);
                        chk_vld_next = issue;
                        chk_idx_next = rd_idx_reg[IDX_W-1:0];
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            free_start_reg <= BYTE_W'(PAGE_BYTES);
            out_valid_reg  <= 1'b0;
            chk_vld_reg    <= 1'b0;
            pend_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            free_start_reg <= free_start_next;
            out_valid_reg  <= out_valid_next;
            chk_vld_reg    <= chk_vld_next;
            pend_vld_reg   <= pend_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        rd_idx_reg  <= rd_idx_next;
        chk_idx_reg <= chk_idx_next;
        off_reg     <= off_next;
        len_reg     <= len_next;
        res_reg     <= res_next;
        pend_reg    <= pend_next;
        out_reg     <= out_next;
    end

endmodule

// ===== tb/spd_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// spd_tb_pkg
// Scoreboard for the slotted page directory: keeps its own copy of the slot
// table, works out the response words of every accepted command word and
// checks the returned words against them in order.
// ----------------------------------------------------------------------------
package spd_tb_pkg;

    import spd_pkg::*;

    class slot_directory_scoreboard;

        logic [BYTE_W-1:0] rec_offset [MAX_ENTRIES];
        logic [BYTE_W-1:0] rec_length [MAX_ENTRIES];
        int unsigned       used_slots;
        int unsigned       free_ptr;
        spd_rsp_t          pending_responses [$];
        int                errors;

        function new();
            used_slots = 0;
            free_ptr   = PAGE_BYTES;
            errors     = 0;
            foreach (rec_offset[i])
            begin
                rec_offset[i] = '0;
                rec_length[i] = '0;
            end
        endfunction

        // bytes left between the directory (with room for one more entry)
        // and the record area; negative once the two have crossed
        function int gap_bytes();
            return int'(free_ptr) - PAGE_HEADER_BYTES - DIR_META_BYTES
                   - int'(used_slots) * ENTRY_BYTES - ENTRY_BYTES;
        endfunction

        function bit has_empty_slot();
            for (int i = 0; i < used_slots; i++)
            begin
                if (rec_length[i] == '0)
                    return 1'b1;
            end
            return 1'b0;
        endfunction

        function void push_response(logic [STAT_W-1:0] st, int unsigned slot,
                                    int unsigned off, int unsigned len, bit fin);
            spd_rsp_t r;
            r.status      = st;
            r.slot_out    = slot[SLOT_W-1:0];
            r.byte_offset = off[BYTE_W-1:0];
            r.byte_length = len[BYTE_W-1:0];
            r.last        = fin;
            pending_responses.push_back(r);
        endfunction

        function void note_command(spd_cmd_t c);
            int unsigned sn;
            int unsigned len;
            int unsigned idx;
            int unsigned live [$];
            sn  = c.slot_number;
            len = c.record_length;
            case (c.command)
                CMD_INSERT:
                begin
                    // gap check comes first, even when a slot would be reused
                    if (gap_bytes() < int'(len))
                    begin
                        push_response(STAT_NO_SPACE, 0, 0, 0, 1'b1);
                        return;
                    end
                    idx = used_slots;
                    for (int i = 0; i < used_slots; i++)
                    begin
                        if (rec_length[i] == '0)
                        begin
                            idx = i;
                            break;
                        end
                    end
                    if (idx == used_slots)
                    begin
                        if (used_slots >= MAX_ENTRIES)
                        begin
                            push_response(STAT_NO_SPACE, 0, 0, 0, 1'b1);
                            return;
                        end
                        used_slots++;
                    end
                    free_ptr        = free_ptr - len;
                    rec_offset[idx] = free_ptr[BYTE_W-1:0];
                    rec_length[idx] = len[BYTE_W-1:0];
                    push_response(STAT_OK, idx, free_ptr, len, 1'b1);
                end
                CMD_REMOVE, CMD_GET:
                begin
                    if (sn >= used_slots)
                        push_response(STAT_BAD_SLOT, 0, 0, 0, 1'b1);
                    else if (c.command == CMD_REMOVE)
                    begin
                        rec_length[sn] = '0;
                        push_response(STAT_OK, sn, 0, 0, 1'b1);
                    end
                    else if (rec_length[sn] == '0)
                        push_response(STAT_EMPTY, sn, 0, 0, 1'b1);
                    else
                        push_response(STAT_OK, sn, rec_offset[sn], rec_length[sn], 1'b1);
                end
                default:
                begin
                    for (int i = 0; i < used_slots; i++)
                    begin
                        if (rec_length[i] != '0)
                            live.push_back(i);
                    end
                    if (live.size() == 0)
                        push_response(STAT_EMPTY, 0, 0, 0, 1'b1);
                    else
                    begin
                        foreach (live[k])
                            push_response(STAT_OK, live[k], rec_offset[live[k]],
                                          rec_length[live[k]], k == live.size() - 1);
                    end
                end
            endcase
        endfunction

        function void check_field(string name, logic [BYTE_W-1:0] want_v,
                                  logic [BYTE_W-1:0] got_v);
            if (got_v !== want_v)
            begin
                $error("%s: expected %0d, got %0d", name, want_v, got_v);
                errors++;
            end
        endfunction

        function void check_response(spd_rsp_t got);
            spd_rsp_t want;
            if (pending_responses.size() == 0)
            begin
                $error("response word with none expected: status %0d slot %0d",
                       got.status, got.slot_out);
                errors++;
                return;
            end
            want = pending_responses.pop_front();
            check_field("status", BYTE_W'(want.status), BYTE_W'(got.status));
            check_field("slot_out", BYTE_W'(want.slot_out), BYTE_W'(got.slot_out));
            check_field("byte_offset", want.byte_offset, got.byte_offset);
            check_field("byte_length", want.byte_length, got.byte_length);
            check_field("last", BYTE_W'(want.last), BYTE_W'(got.last));
        endfunction

    endclass

endpackage

// ===== tb/tb_slotted_page_directory.sv =====
// ----------------------------------------------------------------------------
// tb_slotted_page_directory
// Drives insert, remove, get and scan words into the slot directory with
// random gaps on both sides and checks every response word against the
// scoreboard. A directed opening covers the error cases, random traffic
// follows, and a closing fill runs the page out of slots and space.
// ----------------------------------------------------------------------------
module tb_slotted_page_directory;

    timeunit 1ns;
    timeprecision 1ps;

    import spd_pkg::*;
    import spd_tb_pkg::*;

    localparam int CYCLE_LIMIT      = 2_000_000;
    localparam int RANDOM_PER_PHASE = 125;
    localparam int SPACE_FLOOR      = 480;     // free pointer kept at or above this until the fill
    localparam int HOLD_CYCLES      = 300;
    localparam int DRAIN_CYCLES     = 200;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     cmd_valid = 1'b0;
    logic     cmd_ready;
    spd_cmd_t cmd = '0;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    spd_rsp_t rsp;

    slot_directory_scoreboard sb;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_request = 1'b0;
    int hold_left = 0;
    int cycle_count = 0;
    int fill_gap;

    slotted_page_directory DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ready = 1'b0;
        end
        else
            rsp_ready = ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            sb.check_response(rsp);
    end

    function automatic spd_cmd_t make_cmd(logic [CMD_W-1:0] op, int unsigned sn,
                                          int unsigned len);
        spd_cmd_t c;
        c.command       = op;
        c.slot_number   = sn[SLOT_W-1:0];
        c.record_length = len[BYTE_W-1:0];
        return c;
    endfunction

    // entered and left at a falling edge; valid stays up between back-to-back words
    task automatic send_command(spd_cmd_t c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid = 1'b0;
            cmd       = make_cmd(CMD_W'($urandom_range(3)), $urandom_range(63),
                                 $urandom_range(8191));
            @(negedge clk);
        end
        cmd_valid = 1'b1;
        cmd       = c;
        do
            @(posedge clk);
        while (!cmd_ready);
        sb.note_command(c);
        @(negedge clk);
    endtask

    task automatic issue(logic [CMD_W-1:0] op, int unsigned sn, int unsigned len);
        send_command(make_cmd(op, sn, len));
    endtask

    function automatic spd_cmd_t pick_command();
        int unsigned roll;
        int unsigned sel;
        int unsigned len;
        int unsigned sn;
        int          gap;
        roll = $urandom_range(99);
        gap  = sb.gap_bytes();
        if (roll < 40)
        begin
            sel = $urandom_range(99);
            if (sel < 15)
                len = 0;
            else if (sel < 70)
                len = $urandom_range(16, 1);
            else if (sel < 80)
                len = $urandom_range(100, 17);
            else if (sel < 90)
                len = $urandom_range(8191, 2048);
            else
                len = (gap >= 0) ? gap + $urandom_range(8, 1) : $urandom_range(64);
            // save room for the closing fill
            if (int'(len) <= gap && int'(sb.free_ptr) - int'(len) < SPACE_FLOOR)
                len = gap + 1 + $urandom_range(100);
            // keep the directory below full until the closing fill
            if (int'(len) <= gap && sb.used_slots >= 56 && !sb.has_empty_slot())
                return make_cmd(CMD_REMOVE, $urandom_range(sb.used_slots - 1),
                                $urandom_range(8191));
            return make_cmd(CMD_INSERT, $urandom_range(63), len);
        end
        if (roll >= 85)
            return make_cmd(CMD_SCAN, $urandom_range(63), $urandom_range(8191));
        if (sb.used_slots == 0 || $urandom_range(9) == 0)
            sn = $urandom_range(63, sb.used_slots);
        else
            sn = $urandom_range(sb.used_slots - 1);
        return make_cmd((roll < 60) ? CMD_REMOVE : CMD_GET, sn, $urandom_range(8191));
    endfunction

    initial
    begin
        sb = new();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed opening
        send_idle_pct = 20;
        recv_idle_pct = 30;
        issue(CMD_SCAN, 0, 0);                  // nothing live on an empty page
        issue(CMD_GET, 0, 8191);                // bad slot
        issue(CMD_REMOVE, 63, 0);               // bad slot
        issue(CMD_INSERT, 63, 8191);
        issue(CMD_INSERT, 0, PAGE_BYTES);
        issue(CMD_INSERT, 0, sb.gap_bytes() + 1);
        issue(CMD_INSERT, 0, 0);                // zero-length record, slot stays free
        issue(CMD_GET, 0, 0);                   // empty slot
        issue(CMD_SCAN, 63, 8191);
        issue(CMD_INSERT, 0, 100);              // reuses slot 0
        issue(CMD_INSERT, 0, 1);
        issue(CMD_GET, 1, 0);
        issue(CMD_GET, 2, 0);
        issue(CMD_REMOVE, 0, 0);
        issue(CMD_GET, 0, 0);
        issue(CMD_SCAN, 0, 0);
        issue(CMD_INSERT, 0, 7);
        issue(CMD_SCAN, 0, 0);
        issue(CMD_REMOVE, 1, 0);
        issue(CMD_REMOVE, 1, 0);
        issue(CMD_GET, 63, 0);
        issue(CMD_INSERT, 0, 0);

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 34;
                    recv_idle_pct = 83;
                end
                1:
                begin
                    send_idle_pct = 83;
                    recv_idle_pct = 34;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    hold_request  = 1'b1;   // sender keeps offering words meanwhile
                end
            endcase
            repeat (RANDOM_PER_PHASE)
                send_command(pick_command());
        end

        // closing fill: 63 live slots, then one append that uses up the gap so
        // the directory and record area cross and the gap goes negative
        while (sb.used_slots < MAX_ENTRIES - 1 || sb.has_empty_slot())
            issue(CMD_INSERT, $urandom_range(63), 1);
        issue(CMD_SCAN, 0, 0);
        fill_gap = sb.gap_bytes();
        issue(CMD_INSERT, 0, fill_gap + 1);
        issue(CMD_INSERT, 0, fill_gap);
        issue(CMD_SCAN, 0, 0);                  // every slot live
        issue(CMD_INSERT, 0, 0);
        issue(CMD_REMOVE, 5, 0);
        issue(CMD_INSERT, 0, 0);                // free slot exists but no space
        issue(CMD_GET, 5, 0);
        issue(CMD_GET, 63, 0);
        issue(CMD_SCAN, 0, 0);
        cmd_valid = 1'b0;

        while (sb.pending_responses.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/spd_pkg.sv
rtl/spd_ram.sv
rtl/slotted_page_directory.sv
tb/spd_tb_pkg.sv
tb/tb_slotted_page_directory.sv
